/* src/double_ended_queue_core_macros.svh */
// ----------------------------------------------------------------------------
// double_ended_queue_core_macros.svh
// Assertion macros shared by the deque RTL.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// Checked on every edge outside reset.
`define DQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define DQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Types and constants shared by the deque core, its cell row and its cells.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FUNC_W         = 3;
  localparam int STATUS_W       = 2;
  localparam int VALUE_W        = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_BACK  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_POP_BACK   = 3'd2,
    FN_POP_FRONT  = 3'd3,
    FN_PEEK_FRONT = 3'd4,
    FN_PEEK_BACK  = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Command broadcast to every cell of the row.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_POP_BACK
  } cmd_t;

  // Status of the row as seen by the controller.
  typedef struct packed {
    logic front_valid;  // cell 0 occupied: deque not empty
    logic last_valid;   // last cell occupied: deque full
  } row_stat_t;

endpackage

/* src/dq_cell.sv */
// ----------------------------------------------------------------------------
// dq_cell
// One slot of the deque row: a data word and an occupied flag, updated from
// its neighbors according to the broadcast command.
// ----------------------------------------------------------------------------
module dq_cell #(
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dq_pkg::cmd_t          cmd,
  input  logic [DATA_WIDTH-1:0] push_data,
  input  logic                  left_valid,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic                  right_valid,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic                  valid_o,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] tail_data_o
);

  logic                  valid_r, valid_nxt;
  logic [DATA_WIDTH-1:0] data_r, data_nxt;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    unique case (cmd)
      dq_pkg::CMD_PUSH_FRONT: begin
        valid_nxt = left_valid;
        data_nxt  = left_data;
      end
      dq_pkg::CMD_PUSH_BACK: begin
        // first free slot takes the new word
        valid_nxt = valid_r | left_valid;
        if (!valid_r && left_valid) begin
          data_nxt = push_data;
        end
      end
      dq_pkg::CMD_POP_FRONT: begin
        valid_nxt = right_valid;
        data_nxt  = right_data;
      end
      dq_pkg::CMD_POP_BACK: begin
        valid_nxt = valid_r & right_valid;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_o     = valid_r;
  assign data_o      = data_r;
  // only the back entry drives the shared back-read bus
  assign tail_data_o = (valid_r && !right_valid) ? data_r : '0;

endmodule

/* src/dq_row.sv */
// ----------------------------------------------------------------------------
// dq_row
// Row of DEPTH cells. Cell 0 holds the front entry; occupied cells are always
// a contiguous run from cell 0. The back entry is read through a one-hot OR.
// ----------------------------------------------------------------------------
`include "double_ended_queue_core_macros.svh"

module dq_row #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dq_pkg::cmd_t          cmd,
  input  logic [DATA_WIDTH-1:0] push_data,
  output logic [DATA_WIDTH-1:0] front_data,
  output logic [DATA_WIDTH-1:0] back_data,
  output dq_pkg::row_stat_t     stat
);

  logic [DEPTH-1:0]      valid;
  logic [DATA_WIDTH-1:0] data      [DEPTH];
  logic [DATA_WIDTH-1:0] tail_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  lv, rv;
    logic [DATA_WIDTH-1:0] ld, rd;

    if (i == 0) begin : g_first
      assign lv = 1'b1;
      assign ld = push_data;
    end else begin : g_mid_l
      assign lv = valid[i-1];
      assign ld = data[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign rv = 1'b0;
      assign rd = data[i];
    end else begin : g_mid_r
      assign rv = valid[i+1];
      assign rd = data[i+1];
    end

    dq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .push_data   (push_data),
      .left_valid  (lv),
      .left_data   (ld),
      .right_valid (rv),
      .right_data  (rd),
      .valid_o     (valid[i]),
      .data_o      (data[i]),
      .tail_data_o (tail_data[i])
    );
  end

  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_data = back_data | tail_data[i];
    end
  end

  assign front_data       = data[0];
  assign stat.front_valid = valid[0];
  assign stat.last_valid  = valid[DEPTH-1];

  // occupied cells form a run starting at cell 0
  `DQ_ASSERT(a_valid_contig, $onehot({1'b0, valid} + (DEPTH+1)'(1)), "dq_row: gap in valid run")

endmodule

/* src/double_ended_queue_core.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue built as a row of shifting cells.
//
//   channel | direction | ports                                   | handshake
//   --------+-----------+-----------------------------------------+------------
//   in      | input     | in_func, in_value                       | valid/ready
//   out     | output    | out_status, out_data_out, out_is_empty, | valid/ready
//           |           | out_occupancy                           |
//
// One operation per cycle while in_ready is high: the cells shift or load in the cycle of transfer
// and the result sits in the output register from the next cycle on.
// The cycle is set by the back-read path: a one-hot OR over all DEPTH cells.
// in_ready stays high while the output register is empty or being drained,
// so a stalled out side holds at most one result and then stops input.
// Synchronous reset empties the row (all occupied flags clear).
// ----------------------------------------------------------------------------
`include "double_ended_queue_core_macros.svh"

module double_ended_queue_core #(
  parameter  int DEPTH      = dq_pkg::DEPTH_DEF,
  parameter  int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF,
  localparam int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dq_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [dq_pkg::VALUE_W-1:0] in_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dq_pkg::STATUS_W-1:0]       out_status,
  output logic signed [dq_pkg::VALUE_W-1:0] out_data_out,
  output logic                              out_is_empty,
  output logic [CNT_W-1:0]                  out_occupancy
);

  localparam int VW = dq_pkg::VALUE_W;

  logic                  in_xfer;
  logic [DATA_WIDTH-1:0] push_data;
  logic [DATA_WIDTH-1:0] front_data, back_data;
  dq_pkg::row_stat_t     stat;
  dq_pkg::cmd_t          cmd_c, row_cmd;
  dq_pkg::status_t       status_c;
  logic [DATA_WIDTH-1:0] rd_c;
  logic [VW-1:0]         rd_ext;
  logic                  full, empty;

  // fill count
  logic [CNT_W-1:0] fill_r, fill_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              status_r;
  logic [VW-1:0]           data_out_r;
  logic                    is_empty_r;
  logic [CNT_W-1:0]        occ_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // fit the pushed value to the stored width; fit the read word to 32 bits
  if (DATA_WIDTH <= VW) begin : g_narrow
    assign push_data = in_value[DATA_WIDTH-1:0];
    if (DATA_WIDTH == VW) begin : g_eq
      assign rd_ext = rd_c;
    end else begin : g_lt
      assign rd_ext = {{(VW-DATA_WIDTH){rd_c[DATA_WIDTH-1]}}, rd_c};
    end
  end else begin : g_wide
    assign push_data = {{(DATA_WIDTH-VW){in_value[VW-1]}}, in_value};
    assign rd_ext    = rd_c[VW-1:0];
  end

  assign full  = stat.last_valid;
  assign empty = !stat.front_valid;

  // decode: status, cell command, read word, next fill count
  always_comb begin
    status_c = dq_pkg::ST_OK;
    cmd_c    = dq_pkg::CMD_HOLD;
    rd_c     = '0;
    fill_nxt = fill_r;
    unique case (in_func)
      dq_pkg::FN_PUSH_BACK: begin
        if (full) begin
          status_c = dq_pkg::ST_FULL;
        end else begin
          cmd_c    = dq_pkg::CMD_PUSH_BACK;
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
      dq_pkg::FN_PUSH_FRONT: begin
        if (full) begin
          status_c = dq_pkg::ST_FULL;
        end else begin
          cmd_c    = dq_pkg::CMD_PUSH_FRONT;
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
      dq_pkg::FN_POP_BACK: begin
        if (empty) begin
          status_c = dq_pkg::ST_EMPTY;
        end else begin
          cmd_c    = dq_pkg::CMD_POP_BACK;
          rd_c     = back_data;
          fill_nxt = fill_r - CNT_W'(1);
        end
      end
      dq_pkg::FN_POP_FRONT: begin
        if (empty) begin
          status_c = dq_pkg::ST_EMPTY;
        end else begin
          cmd_c    = dq_pkg::CMD_POP_FRONT;
          rd_c     = front_data;
          fill_nxt = fill_r - CNT_W'(1);
        end
      end
      dq_pkg::FN_PEEK_FRONT: begin
        if (empty) begin
          status_c = dq_pkg::ST_EMPTY;
        end else begin
          rd_c = front_data;
        end
      end
      dq_pkg::FN_PEEK_BACK: begin
        if (empty) begin
          status_c = dq_pkg::ST_EMPTY;
        end else begin
          rd_c = back_data;
        end
      end
      default: begin
        // unknown code: no change, ok status
      end
    endcase
  end

  assign row_cmd = in_xfer ? cmd_c : dq_pkg::CMD_HOLD;

  dq_row #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_row (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (row_cmd),
    .push_data  (push_data),
    .front_data (front_data),
    .back_data  (back_data),
    .stat       (stat)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_xfer) begin
        fill_r <= fill_nxt;
      end
    end
  end

  // result payload, loaded on every input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r   <= status_c;
      data_out_r <= rd_ext;
      is_empty_r <= (fill_nxt == '0);
      occ_r      <= fill_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_data_out  = data_out_r;
  assign out_is_empty  = is_empty_r;
  assign out_occupancy = occ_r;

  // fill count tracks the row's occupied flags at both ends
  `DQ_ASSERT(a_empty_match, ((fill_r == '0) == empty), "dq: fill count and front flag disagree")
  `DQ_ASSERT(a_full_match, ((fill_r == CNT_W'(DEPTH)) == full), "dq: fill count and last flag disagree")
  `DQ_ASSERT(a_fill_bound, (fill_r <= CNT_W'(DEPTH)), "dq: fill count above depth")
  // refused push leaves the count alone
  `DQ_ASSERT(a_full_hold, (in_xfer && status_c == dq_pkg::ST_FULL) |=> (fill_r == $past(fill_r)), "dq: refused push changed count")

endmodule
